### design/sgcb_pkg.sv
`default_nettype none
package sgcb_pkg;

    localparam int CELLS_W    = 7;
    localparam int INV_W      = 24;
    localparam int PROD_SHIFT = 24;
    localparam int INDEX_W    = 18;
    localparam int TAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE_Z = 3'd5;

    localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd64;
    localparam logic [INV_W-1:0]   INV_RESET   = 24'd65536;

endpackage
`default_nettype wire

### design/sgcb_body_if.sv
`default_nettype none
interface sgcb_body_if import sgcb_pkg::*; #(
    parameter int COORD_BITS = 24
) ();
    logic                    valid;
    logic                    ready;
    logic [COORD_BITS-1:0]   pos_x;
    logic [COORD_BITS-1:0]   pos_y;
    logic [COORD_BITS-1:0]   pos_z;
    logic [COORD_BITS-2:0]   half_extent;
    logic [TAG_W-1:0]        body_id;

    modport source (output valid, pos_x, pos_y, pos_z, half_extent, body_id, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, half_extent, body_id, output ready);
endinterface
`default_nettype wire

### design/sgcb_cell_if.sv
`default_nettype none
interface sgcb_cell_if import sgcb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] cell_index;
    logic [TAG_W-1:0]   body_tag;
    logic               last_cell;
    logic               span_cut;

    modport source (output valid, cell_index, body_tag, last_cell, span_cut, input ready);
    modport sink   (input valid, cell_index, body_tag, last_cell, span_cut, output ready);
endinterface
`default_nettype wire

### design/sphere_to_grid_cell_binning_unit.sv
// Uniform grid cell binning: each body item (signed Q.8 centre, unsigned Q.8 half
// extent, id) is mapped per axis to a lower and upper cell using the Q8.16
// reciprocal cell sizes, clamped to the grid, and one output item is sent for
// every covered cell, x outermost, then z, then y, with last_cell on the final
// one and span_cut when an axis span was limited to MAX_SPAN cells. A body first
// passes a five-stage pipeline (extent add, multiply, clamp, span/stride multiply,
// index sum), then a cell enumerator sends one output item per cycle while
// o_cell.ready is high. A body covering N cells (1 to MAX_SPAN cubed) holds the
// enumerator until all N are sent while later bodies fill the pipeline; the next
// body is loaded in the cycle its predecessor's last cell is accepted. Cell counts
// of 0 act as 1, counts above MAX_CELLS_AXIS act as MAX_CELLS_AXIS. Write the
// configuration registers only while no body is in flight.
`default_nettype none
module sphere_to_grid_cell_binning_unit import sgcb_pkg::*; #(
    parameter int MAX_CELLS_AXIS = 64,
    parameter int MAX_SPAN       = 4,
    parameter int COORD_BITS     = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sgcb_body_if.sink                  i_body,
    sgcb_cell_if.source                o_cell
);

    localparam int CB  = COORD_BITS;
    localparam int CW  = $clog2(MAX_CELLS_AXIS);
    localparam int SPW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int PW  = CB + INV_W;
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    function automatic logic [CW-1:0] f_top_cell(input logic [CELLS_W-1:0] c);
        logic [CW-1:0] res;
        if (c == '0) begin
            res = '0;
        end else if (int'(c) > MAX_CELLS_AXIS) begin
            res = CW'(MAX_CELLS_AXIS - 1);
        end else begin
            res = CW'(c - 1'b1);
        end
        return res;
    endfunction

    // configuration registers
    logic [CELLS_W-1:0] r_cells [3];
    logic [INV_W-1:0]   r_inv   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_cells[a] <= CELLS_RESET;
                r_inv[a]   <= INV_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELLS_X:    r_cells[AX_X] <= i_cfg_data[CELLS_W-1:0];
                CFG_CELLS_Y:    r_cells[AX_Y] <= i_cfg_data[CELLS_W-1:0];
                CFG_CELLS_Z:    r_cells[AX_Z] <= i_cfg_data[CELLS_W-1:0];
                CFG_INV_SIZE_X: r_inv[AX_X]   <= i_cfg_data[INV_W-1:0];
                CFG_INV_SIZE_Y: r_inv[AX_Y]   <= i_cfg_data[INV_W-1:0];
                CFG_INV_SIZE_Z: r_inv[AX_Z]   <= i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective grid size and strides
    logic [CW-1:0]      w_top [3];
    logic [INDEX_W-1:0] w_n   [3];
    logic [INDEX_W-1:0] w_nxnz;
    logic [INDEX_W-1:0] r_nxnz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_top[a] = f_top_cell(r_cells[a]);
            w_n[a]   = INDEX_W'(w_top[a]) + INDEX_W'(1);
        end
        w_nxnz = INDEX_W'(w_n[AX_X] * w_n[AX_Z]);
    end

    always_ff @(posedge i_clk) begin
        r_nxnz <= w_nxnz;
    end

    // flow control
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_e_valid;
    logic w_e_last;
    logic w_step, w_free, w_load, w_adv;

    assign w_step = r_e_valid && o_cell.ready;
    assign w_free = !r_e_valid || (w_step && w_e_last);
    assign w_load = w_free && r_v5;
    assign w_adv  = !r_v5 || w_free;

    assign i_body.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_v1 <= i_body.valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
            end
            if (w_free) begin
                r_e_valid <= r_v5;
            end
        end
    end

    // stage 1: extent bounds, non-positive bounds forced to zero
    logic [CB-1:0]   w_pos [3];
    logic signed [CB:0] w_lo_s [3];
    logic signed [CB:0] w_hi_s [3];
    logic [CB-1:0]   w_lo_c [3];
    logic [CB-1:0]   w_hi_c [3];

    assign w_pos[AX_X] = i_body.pos_x;
    assign w_pos[AX_Y] = i_body.pos_y;
    assign w_pos[AX_Z] = i_body.pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_lo_s[a] = signed'({w_pos[a][CB-1], w_pos[a]}) - signed'({2'b00, i_body.half_extent});
            w_hi_s[a] = signed'({w_pos[a][CB-1], w_pos[a]}) + signed'({2'b00, i_body.half_extent});
            w_lo_c[a] = (!w_lo_s[a][CB] && (w_lo_s[a] != '0)) ? w_lo_s[a][CB-1:0] : '0;
            w_hi_c[a] = (!w_hi_s[a][CB] && (w_hi_s[a] != '0)) ? w_hi_s[a][CB-1:0] : '0;
        end
    end

    logic [CB-1:0]    r1_lo [3];
    logic [CB-1:0]    r1_hi [3];
    logic [TAG_W-1:0] r1_tag;

    // stage 2: scale by reciprocal cell size
    logic [PW-1:0]    w_plo [3];
    logic [PW-1:0]    w_phi [3];
    logic [CB-1:0]    r2_lo [3];
    logic [CB-1:0]    r2_hi [3];
    logic [TAG_W-1:0] r2_tag;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_plo[a] = PW'(r1_lo[a]) * PW'(r_inv[a]);
            w_phi[a] = PW'(r1_hi[a]) * PW'(r_inv[a]);
        end
    end

    // stage 3: clamp to grid
    logic [CW-1:0]    r3_lo [3];
    logic [CW-1:0]    r3_hi [3];
    logic [TAG_W-1:0] r3_tag;

    // stage 4: span limit, index partial products
    logic [CW-1:0]    w_d   [3];
    logic             w_cut [3];
    logic [SPW-1:0]   w_sp  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a]   = r3_hi[a] - r3_lo[a];
            w_cut[a] = int'(w_d[a]) >= MAX_SPAN;
            w_sp[a]  = w_cut[a] ? SPW'(MAX_SPAN - 1) : SPW'(w_d[a]);
        end
    end

    logic [INDEX_W-1:0] r4_xt, r4_zt, r4_yt;
    logic [SPW-1:0]     r4_sp [3];
    logic               r4_cut;
    logic [TAG_W-1:0]   r4_tag;

    // stage 5: base index
    logic [INDEX_W-1:0] r5_base;
    logic [SPW-1:0]     r5_sp [3];
    logic               r5_cut;
    logic [TAG_W-1:0]   r5_tag;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r1_lo[a] <= w_lo_c[a];
                r1_hi[a] <= w_hi_c[a];
                r2_lo[a] <= CB'(w_plo[a] >> PROD_SHIFT);
                r2_hi[a] <= CB'(w_phi[a] >> PROD_SHIFT);
                r3_lo[a] <= (r2_lo[a] > CB'(w_top[a])) ? w_top[a] : r2_lo[a][CW-1:0];
                r3_hi[a] <= (r2_hi[a] > CB'(w_top[a])) ? w_top[a] : r2_hi[a][CW-1:0];
                r4_sp[a] <= w_sp[a];
                r5_sp[a] <= r4_sp[a];
            end
            r1_tag  <= i_body.body_id;
            r2_tag  <= r1_tag;
            r3_tag  <= r2_tag;
            r4_xt   <= INDEX_W'(r3_lo[AX_X]);
            r4_zt   <= INDEX_W'(INDEX_W'(r3_lo[AX_Z]) * w_n[AX_X]);
            r4_yt   <= INDEX_W'(INDEX_W'(r3_lo[AX_Y]) * r_nxnz);
            r4_cut  <= w_cut[AX_X] || w_cut[AX_Y] || w_cut[AX_Z];
            r4_tag  <= r3_tag;
            r5_base <= r4_xt + r4_zt + r4_yt;
            r5_cut  <= r4_cut;
            r5_tag  <= r4_tag;
        end
    end

    // cell enumerator: x outer, z middle, y inner
    logic [INDEX_W-1:0] r_idx, r_row, r_plane;
    logic [SPW-1:0]     r_cx, r_cz, r_cy;
    logic [SPW-1:0]     r_sx, r_sz, r_sy;
    logic               r_e_cut;
    logic [TAG_W-1:0]   r_e_tag;

    assign w_e_last = (r_cx == r_sx) && (r_cz == r_sz) && (r_cy == r_sy);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_idx   <= r5_base;
            r_row   <= r5_base;
            r_plane <= r5_base;
            r_cx    <= '0;
            r_cz    <= '0;
            r_cy    <= '0;
            r_sx    <= r5_sp[AX_X];
            r_sy    <= r5_sp[AX_Y];
            r_sz    <= r5_sp[AX_Z];
            r_e_cut <= r5_cut;
            r_e_tag <= r5_tag;
        end else if (w_step && !w_e_last) begin
            if (r_cy != r_sy) begin
                r_cy  <= r_cy + 1'b1;
                r_idx <= r_idx + r_nxnz;
            end else if (r_cz != r_sz) begin
                r_cy  <= '0;
                r_cz  <= r_cz + 1'b1;
                r_row <= r_row + w_n[AX_X];
                r_idx <= r_row + w_n[AX_X];
            end else begin
                r_cy    <= '0;
                r_cz    <= '0;
                r_cx    <= r_cx + 1'b1;
                r_plane <= r_plane + INDEX_W'(1);
                r_row   <= r_plane + INDEX_W'(1);
                r_idx   <= r_plane + INDEX_W'(1);
            end
        end
    end

    assign o_cell.valid      = r_e_valid;
    assign o_cell.cell_index = r_idx;
    assign o_cell.body_tag   = r_e_tag;
    assign o_cell.last_cell  = w_e_last;
    assign o_cell.span_cut   = r_e_cut;

endmodule
`default_nettype wire
